/* hw/rtl/bba_pkg.sv */
package bba_pkg;

    localparam int NumPages     = 16;
    localparam int PageBytes    = 4096;
    localparam int MinShift     = 5;
    localparam int LevelCount   = 8;
    localparam int HeaderBytes  = 24;
    localparam int SlotsPerPage = PageBytes >> MinShift;
    localparam int Slots        = NumPages * SlotsPerPage;
    localparam int SlotW        = $clog2(Slots);
    localparam int PtrW         = SlotW + 1;
    localparam int LvlW         = 3;
    localparam int PageW        = $clog2(NumPages + 1);
    localparam int Top          = LevelCount - 1;

    localparam logic [PtrW-1:0] Nil = {PtrW{1'b1}};

    localparam logic [2:0] OcAlloc    = 3'd0;
    localparam logic [2:0] OcFreed    = 3'd1;
    localparam logic [2:0] OcNull     = 3'd2;
    localparam logic [2:0] OcTooLarge = 3'd3;
    localparam logic [2:0] OcExhaust  = 3'd4;

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_bytes;
        logic [15:0] user_address;
    } bba_req_t;

    typedef struct packed {
        logic [15:0] address;
        logic [2:0]  outcome;
        logic [16:0] pool_bytes;
        logic [16:0] free_bytes;
    } bba_res_t;

    // one header entry per slot
    typedef struct packed {
        logic            free;
        logic [LvlW-1:0] level;
        logic [PtrW-1:0] next;
        logic [PtrW-1:0] prev;
    } bba_hdr_t;

    // memory port requests from the sequencer
    typedef struct packed {
        logic             rd;
        logic [SlotW-1:0] raddr;
        logic             wr;
        logic [SlotW-1:0] waddr;
        bba_hdr_t         wdata;
    } bba_mem_t;

    function automatic logic [16:0] blk_size(input logic [LvlW-1:0] lvl);
        blk_size = 17'd1 << (lvl + MinShift);
    endfunction

endpackage

/* hw/rtl/bba_hdr_mem.sv */
module bba_hdr_mem (
    input  logic              clk,
    input  bba_pkg::bba_mem_t mem,
    output bba_pkg::bba_hdr_t rdata
);
    import bba_pkg::*;

    bba_hdr_t store [Slots];

    // header store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem.wr)
        begin
            store[mem.waddr] <= mem.wdata;
        end
        if (mem.rd)
        begin
            rdata <= store[mem.raddr];
        end
    end

endmodule

/* hw/rtl/buddy_block_allocator.sv */
// Buddy allocator over 16 pages of 4096 bytes, blocks of 32 to 4096 bytes
// (levels 0 to 7) with one lifo free list per level. Pulse start with a
// request while busy is low; busy then stays high until the result appears
// for exactly one cycle with done high. The receiver cannot stall, so the
// result must be captured in that cycle. Per-slot headers (free flag, level,
// list links) live in a 2048-entry single-port-per-direction memory. After
// reset the block runs a clearing pass over all 2048 headers with busy
// high. An allocate scans the levels from the wanted one upward, unlinks
// a listed block or opens a new page, splits it level by level down to
// the wanted level and then finishes. A free reads the header, then merges
// level by level, with a buddy check that ends a merge below the top level,
// and finally pushes the block onto its list. Each list operation goes
// through the header memory.
module buddy_block_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bba_pkg::bba_req_t request,
    output logic              busy,
    output logic              done,
    output bba_pkg::bba_res_t result
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_FIND, S_A_RD, S_A_UNL, S_SPLIT, S_PUSH_RD,
        S_PUSH_W, S_PUSH_PREV, S_A_FIN, S_F_RD, S_F_CHK, S_B_RD, S_B_CHK,
        S_UNL_P, S_UNL_N, S_UNL_FIX, S_F_PUSH, S_DONE
    } state_t;

    state_t           state_reg;
    logic [SlotW:0]   clr_reg;
    logic [PtrW-1:0]  head_reg [LevelCount];
    logic [PageW-1:0] pages_reg;
    logic [16:0]      ftot_reg;
    logic [SlotW-1:0] s_reg;     // working slot
    logic [SlotW-1:0] b_reg;     // buddy slot
    logic [LvlW-1:0]  want_reg;
    logic [LvlW:0]    j_reg;     // current level
    logic             is_free_reg;
    logic [15:0]      addr_reg;
    logic [2:0]       oc_reg;
    bba_hdr_t         cur_reg;   // header being unlinked
    state_t           ret_reg;   // where unlink returns
    logic             done_reg;

    bba_mem_t mem;
    bba_hdr_t rdata;

    bba_hdr_mem u_mem (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );

    // request size to level, total fits in 17 bits
    logic [16:0]     total;
    logic [LvlW:0]   want_c;
    always_comb
    begin
        total  = {1'b0, request.request_bytes} + 17'(HeaderBytes);
        want_c = 4'd8;
        for (int i = LevelCount - 1; i >= 0; i--)
        begin
            if (total <= (17'd1 << (i + MinShift)))
            begin
                want_c = 4'(i);
            end
        end
    end

    // free address decode
    logic [15:0] blk;
    assign blk = request.user_address - 16'(HeaderBytes);

    logic [LvlW-1:0] jl;
    assign jl = j_reg[LvlW-1:0];

    always_comb
    begin
        mem = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem.wr    = 1'b1;
                mem.waddr = clr_reg[SlotW-1:0];
                mem.wdata = '{free: 1'b0, level: '0, next: Nil, prev: Nil};
            end
            S_A_RD:
            begin
                mem.rd    = 1'b1;
                mem.raddr = head_reg[jl][SlotW-1:0];
            end
            S_PUSH_W:
            begin
                mem.wr    = 1'b1;
                mem.waddr = s_reg;
                mem.wdata = '{free: 1'b1, level: jl, next: head_reg[jl], prev: Nil};
                mem.rd    = !head_reg[jl][SlotW];
                mem.raddr = head_reg[jl][SlotW-1:0];
            end
            S_PUSH_PREV:
            begin
                mem.wr    = !head_reg[jl][SlotW];
                mem.waddr = head_reg[jl][SlotW-1:0];
                mem.wdata = rdata;
                mem.wdata.prev = {1'b0, s_reg};
            end
            S_A_FIN:
            begin
                mem.wr    = 1'b1;
                mem.waddr = s_reg;
                mem.wdata = '{free: 1'b0, level: want_reg, next: Nil, prev: Nil};
            end
            S_F_RD:
            begin
                mem.rd    = 1'b1;
                mem.raddr = s_reg;
            end
            S_B_RD:
            begin
                mem.rd    = 1'b1;
                mem.raddr = b_reg;
            end
            S_UNL_P:
            begin
                mem.rd    = !cur_reg.prev[SlotW];
                mem.raddr = cur_reg.prev[SlotW-1:0];
            end
            S_UNL_N:
            begin
                mem.wr    = !cur_reg.prev[SlotW];
                mem.waddr = cur_reg.prev[SlotW-1:0];
                mem.wdata = rdata;
                mem.wdata.next = cur_reg.next;
                mem.rd    = !cur_reg.next[SlotW];
                mem.raddr = cur_reg.next[SlotW-1:0];
            end
            S_UNL_FIX:
            begin
                mem.wr    = !cur_reg.next[SlotW];
                mem.waddr = cur_reg.next[SlotW-1:0];
                mem.wdata = rdata;
                mem.wdata.prev = cur_reg.prev;
            end
            S_F_PUSH:
            begin
                // unlinked buddy is no longer free; an upper one also loses its level
                mem.wr    = (ret_reg == S_F_PUSH) && (b_reg != s_reg);
                mem.waddr = b_reg;
                mem.wdata = '{free: 1'b0, level: jl, next: Nil, prev: Nil};
                if (b_reg > s_reg)
                begin
                    mem.wdata.level = '0;
                end
            end
            default:
            begin
                mem = '0;
            end
        endcase
    end

    // unlinked buddy of a free is cleared in the merge step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pages_reg   <= '0;
            ftot_reg    <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < LevelCount; i++)
            begin
                head_reg[i] <= Nil;
            end
            s_reg       <= '0;
            b_reg       <= '0;
            want_reg    <= '0;
            j_reg       <= '0;
            is_free_reg <= 1'b0;
            addr_reg    <= '0;
            oc_reg      <= '0;
            cur_reg     <= '0;
            ret_reg     <= S_IDLE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SlotW+1)'(Slots - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg <= '0;
                        oc_reg   <= OcNull;
                        if (request.command == CmdAlloc)
                        begin
                            want_reg <= want_c[LvlW-1:0];
                            j_reg    <= {1'b0, want_c[LvlW-1:0]};
                            if (request.request_bytes == '0)
                            begin
                                state_reg <= S_DONE;
                            end
                            else if (want_c[LvlW])
                            begin
                                oc_reg    <= OcTooLarge;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_A_FIND;
                            end
                        end
                        else
                        begin
                            s_reg <= blk[MinShift +: SlotW];
                            if (request.user_address < 16'(HeaderBytes)
                                || blk[MinShift-1:0] != '0
                                || {1'b0, blk[15:MinShift]} >=
                                   12'({pages_reg, 7'd0}))
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_F_RD;
                            end
                        end
                    end
                end
                // scan levels one per cycle
                S_A_FIND:
                begin
                    if (j_reg[LvlW])
                    begin
                        if (pages_reg >= PageW'(NumPages))
                        begin
                            oc_reg    <= OcExhaust;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            s_reg     <= SlotW'({pages_reg, 7'd0});
                            pages_reg <= pages_reg + 1'b1;
                            j_reg     <= 4'(Top);
                            state_reg <= S_SPLIT;
                        end
                    end
                    else if (!head_reg[jl][SlotW])
                    begin
                        state_reg <= S_A_RD;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_A_RD:
                begin
                    s_reg     <= head_reg[jl][SlotW-1:0];
                    state_reg <= S_A_UNL;
                end
                S_A_UNL:
                begin
                    cur_reg   <= rdata;
                    ret_reg   <= S_SPLIT;
                    state_reg <= S_UNL_P;
                end
                S_SPLIT:
                begin
                    if (j_reg > {1'b0, want_reg})
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_PUSH_W;
                    end
                    else
                    begin
                        state_reg <= S_A_FIN;
                    end
                end
                S_PUSH_W:
                begin
                    ftot_reg  <= ftot_reg + blk_size(jl);
                    state_reg <= S_PUSH_PREV;
                end
                S_PUSH_PREV:
                begin
                    head_reg[jl] <= {1'b0, s_reg};
                    if (is_free_reg)
                    begin
                        oc_reg    <= OcFreed;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        s_reg     <= s_reg | (SlotW'(1) << jl);
                        state_reg <= S_SPLIT;
                    end
                end
                S_A_FIN:
                begin
                    oc_reg    <= OcAlloc;
                    addr_reg  <= 16'({s_reg, 5'd0}) + 16'(HeaderBytes);
                    state_reg <= S_DONE;
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (rdata.free
                        || (s_reg & ((SlotW'(1) << rdata.level) - 1'b1)) != '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        is_free_reg <= 1'b1;
                        j_reg       <= {1'b0, rdata.level};
                        b_reg       <= s_reg ^ (SlotW'(1) << rdata.level);
                        state_reg   <= (rdata.level < LvlW'(Top)) ? S_B_RD : S_PUSH_W;
                    end
                end
                S_B_RD:
                begin
                    state_reg <= S_B_CHK;
                end
                S_B_CHK:
                begin
                    if (rdata.free && rdata.level == jl)
                    begin
                        cur_reg   <= rdata;
                        ret_reg   <= S_F_PUSH;
                        state_reg <= S_UNL_P;
                    end
                    else
                    begin
                        b_reg     <= s_reg;
                        state_reg <= S_PUSH_W;
                    end
                end
                S_UNL_P:
                begin
                    if (cur_reg.prev[SlotW])
                    begin
                        head_reg[cur_reg.level] <= cur_reg.next;
                    end
                    ftot_reg  <= ftot_reg - blk_size(cur_reg.level);
                    state_reg <= S_UNL_N;
                end
                S_UNL_N:
                begin
                    state_reg <= S_UNL_FIX;
                end
                S_UNL_FIX:
                begin
                    state_reg <= ret_reg;
                end
                // merge step; also writes back the absorbed slot
                S_F_PUSH:
                begin
                    if (ret_reg == S_F_PUSH && b_reg != s_reg)
                    begin
                        ret_reg <= S_IDLE;
                        if (b_reg < s_reg)
                        begin
                            s_reg <= b_reg;
                        end
                        j_reg <= j_reg + 1'b1;
                        if (j_reg + 1'b1 < 4'(Top))
                        begin
                            b_reg     <= (b_reg < s_reg ? b_reg : s_reg)
                                         ^ (SlotW'(1) << (jl + 1'b1));
                            state_reg <= S_B_RD;
                        end
                        else
                        begin
                            b_reg     <= (b_reg < s_reg ? b_reg : s_reg);
                            state_reg <= S_PUSH_W;
                        end
                    end
                    else
                    begin
                        b_reg     <= s_reg;
                        state_reg <= S_PUSH_W;
                    end
                end
                S_DONE:
                begin
                    is_free_reg <= 1'b0;
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result.address    = addr_reg;
    assign result.outcome    = oc_reg;
    assign result.pool_bytes = 17'({pages_reg, 12'd0});
    assign result.free_bytes = ftot_reg;

endmodule
